### rtl/core/lock_order_deadlock_detector_defines.svh
// Assertion macros shared by the lock order deadlock detector.
`ifndef LOCK_ORDER_DEADLOCK_DETECTOR_DEFINES_SVH
`define LOCK_ORDER_DEADLOCK_DETECTOR_DEFINES_SVH

`define LODD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock order detector assertion failed");

`define LODD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock order detector assertion failed");

`endif

### rtl/core/lodd_pkg.sv
package lodd_pkg;

    localparam int ID_W    = 32;
    localparam int THREADS = 16;
    localparam int TW      = $clog2(THREADS);
    localparam int LOCKS   = 128;
    localparam int LW      = $clog2(LOCKS);
    localparam int DW      = $clog2(LOCKS + 1);
    localparam int HOLDS   = 32;
    localparam int HW      = $clog2(HOLDS);
    localparam int HCW     = $clog2(HOLDS + 1);
    localparam int HDEPTH  = THREADS * HOLDS;
    localparam int STK_W   = 2 * LW;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_HELD_ERR   = 2'd1;
    localparam t_status ST_THREAD_ERR = 2'd2;

    localparam logic FN_LOCK   = 1'b0;
    localparam logic FN_UNLOCK = 1'b1;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] thread_id;
        logic [ID_W-1:0] lock_id;
    } t_req;

    typedef struct packed {
        t_status status;
        logic    cycle_found;
    } t_rsp;

endpackage

### rtl/core/lodd_ram.sv
module lodd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/lock_order_deadlock_detector.sv
// Channel   Ports                  Handshake
// request   i_req (t_req)          taken when start is high and busy is low
// result    o_rsp (t_rsp)          valid for the one cycle o_strobe is high
//
// Only one transaction is in flight; busy stays high until its result is shown.
// Unlock does a node lookup, an edge column sweep if the node is found, and a hold
// lookup; both lookups go through the single id comparator.
// Lock does a hold lookup and up to HOLDS+1 node lookups, then a depth-first search
// that scans each node's edge row one bit a cycle.
// Reset is synchronous and needs no clearing pass; the receiver cannot stall.
`include "lock_order_deadlock_detector_defines.svh"

module lock_order_deadlock_detector
    import lodd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_rsp o_rsp
);

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_THR   = 21'h000002,
        S_HRD   = 21'h000004,
        S_HCMP  = 21'h000008,
        S_HDONE = 21'h000010,
        S_NRD   = 21'h000020,
        S_NCMP  = 21'h000040,
        S_NDONE = 21'h000080,
        S_ERD   = 21'h000100,
        S_ECHK  = 21'h000200,
        S_EDRD  = 21'h000400,
        S_EDWR  = 21'h000800,
        S_HWR   = 21'h001000,
        S_CRD   = 21'h002000,
        S_CWR   = 21'h004000,
        S_SINIT = 21'h008000,
        S_SROOT = 21'h010000,
        S_SROW  = 21'h020000,
        S_SSCAN = 21'h040000,
        S_SPOP  = 21'h080000,
        S_OUT   = 21'h100000
    } t_state;

    localparam logic [LW-1:0] LAST_NODE = LW'(LOCKS - 1);

    t_state r_state, n_state;
    logic [ID_W-1:0] r_slot [THREADS];
    logic [ID_W-1:0] n_slot [THREADS];
    logic [HCW-1:0] r_fill [THREADS];
    logic [HCW-1:0] n_fill [THREADS];
    logic [LOCKS-1:0] r_nvalid, n_nvalid, r_rvalid, n_rvalid;
    logic [LOCKS-1:0] r_visit, n_visit, r_stk, n_stk;

    t_req r_req;
    logic [TW-1:0] r_ti, n_ti;
    logic [HCW-1:0] r_hi, n_hi;
    logic r_mf, n_mf, r_zf, n_zf;
    logic [HW-1:0] r_midx, n_midx, r_zidx, n_zidx;
    logic [ID_W-1:0] r_key, n_key;
    logic [LW-1:0] r_ni, n_ni, r_nidx, n_nidx, r_eidx, n_eidx;
    logic r_nf, n_nf, r_ef, n_ef, r_edge, n_edge;
    logic [LW-1:0] r_node, n_node, r_src, n_src, r_ci, n_ci;
    logic [LW-1:0] r_root, n_root, r_top, n_top, r_cur, n_cur;
    logic [DW-1:0] r_depth, n_depth;
    logic [LOCKS-1:0] r_row, n_row;
    t_status r_status, n_status;
    logic r_cyc, n_cyc;

    logic held_we;
    logic [TW+HW-1:0] held_waddr, held_raddr;
    logic [ID_W-1:0] held_wdata, held_rdata;
    logic node_we;
    logic [LW-1:0] node_waddr, node_raddr;
    logic [ID_W-1:0] node_wdata, node_rdata;
    logic edge_we;
    logic [LW-1:0] edge_waddr, edge_raddr;
    logic [LOCKS-1:0] edge_wdata, edge_rdata;
    logic stk_we;
    logic [LW-1:0] stk_waddr, stk_raddr;
    logic [STK_W-1:0] stk_wdata, stk_rdata;

    logic [ID_W-1:0] cmp_data;
    logic cmp_eq;
    logic [LOCKS-1:0] node_bit;
    logic [DW-1:0] dm1, dm2;
    logic thr_hit, thr_free;
    logic [TW-1:0] thr_hit_idx, thr_free_idx;
    logic scan_edge;

    lodd_ram #(.WIDTH(ID_W), .DEPTH(HDEPTH)) u_held_ram (
        .i_clk(i_clk), .i_we(held_we), .i_waddr(held_waddr), .i_wdata(held_wdata),
        .i_raddr(held_raddr), .o_rdata(held_rdata)
    );

    lodd_ram #(.WIDTH(ID_W), .DEPTH(LOCKS)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    lodd_ram #(.WIDTH(LOCKS), .DEPTH(LOCKS)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    lodd_ram #(.WIDTH(STK_W), .DEPTH(LOCKS)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // The single id comparator serves both the hold list and the node table scans.
    assign cmp_data = (r_state == S_NCMP) ? node_rdata : held_rdata;
    assign cmp_eq   = (cmp_data == r_key);
    assign node_bit = {{(LOCKS-1){1'b0}}, 1'b1} << r_node;
    assign dm1      = r_depth - DW'(1);
    assign dm2      = r_depth - DW'(2);
    assign scan_edge = r_row[r_cur] && r_nvalid[r_cur];

    always_comb begin
        thr_hit      = 1'b0;
        thr_hit_idx  = '0;
        thr_free     = 1'b0;
        thr_free_idx = '0;
        for (int k = THREADS - 1; k >= 0; k--) begin
            if (r_slot[k] == r_req.thread_id && r_req.thread_id != '0) begin
                thr_hit     = 1'b1;
                thr_hit_idx = TW'(k);
            end
            if (r_slot[k] == '0) begin
                thr_free     = 1'b1;
                thr_free_idx = TW'(k);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_fill   = r_fill;
        n_nvalid = r_nvalid;
        n_rvalid = r_rvalid;
        n_visit  = r_visit;
        n_stk    = r_stk;
        n_ti     = r_ti;
        n_hi     = r_hi;
        n_mf     = r_mf;
        n_zf     = r_zf;
        n_midx   = r_midx;
        n_zidx   = r_zidx;
        n_key    = r_key;
        n_ni     = r_ni;
        n_nidx   = r_nidx;
        n_eidx   = r_eidx;
        n_nf     = r_nf;
        n_ef     = r_ef;
        n_edge   = r_edge;
        n_node   = r_node;
        n_src    = r_src;
        n_ci     = r_ci;
        n_root   = r_root;
        n_top    = r_top;
        n_cur    = r_cur;
        n_depth  = r_depth;
        n_row    = r_row;
        n_status = r_status;
        n_cyc    = r_cyc;

        held_we    = 1'b0;
        held_waddr = {r_ti, r_zidx};
        held_wdata = '0;
        held_raddr = {r_ti, r_hi[HW-1:0]};
        node_we    = 1'b0;
        node_waddr = r_eidx;
        node_wdata = r_key;
        node_raddr = r_ni;
        edge_we    = 1'b0;
        edge_waddr = r_src;
        edge_wdata = '0;
        edge_raddr = r_src;
        stk_we     = 1'b0;
        stk_waddr  = dm1[LW-1:0];
        stk_wdata  = {r_top, r_cur};
        stk_raddr  = dm2[LW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cyc = 1'b0;
                    if (i_req.func == FN_LOCK) begin
                        n_state = S_THR;
                    end else begin
                        n_key   = i_req.lock_id;
                        n_ni    = '0;
                        n_nf    = 1'b0;
                        n_ef    = 1'b0;
                        n_edge  = 1'b0;
                        n_state = S_NRD;
                    end
                end
            end
            S_THR: begin
                n_hi  = '0;
                n_mf  = 1'b0;
                n_zf  = 1'b0;
                n_key = r_req.lock_id;
                if (r_req.func == FN_LOCK) begin
                    if (thr_hit) begin
                        n_ti = thr_hit_idx;
                    end else if (thr_free && r_req.thread_id != '0) begin
                        n_ti = thr_free_idx;
                        n_slot[thr_free_idx] = r_req.thread_id;
                    end
                    if (!thr_hit && !(thr_free && r_req.thread_id != '0)) begin
                        n_status = ST_THREAD_ERR;
                        n_state  = S_SINIT;
                    end else if (r_req.lock_id == '0) begin
                        n_status = ST_OK;
                        n_state  = S_SINIT;
                    end else begin
                        n_state = S_HRD;
                    end
                end else begin
                    n_ti = thr_hit_idx;
                    if (!thr_hit) begin
                        n_status = ST_THREAD_ERR;
                        n_state  = S_OUT;
                    end else if (r_req.lock_id == '0) begin
                        n_status = ST_HELD_ERR;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_HRD;
                    end
                end
            end
            S_HRD: begin
                if (r_hi >= r_fill[r_ti]) begin
                    if (!r_zf && r_fill[r_ti] < HCW'(HOLDS)) begin
                        n_zf   = 1'b1;
                        n_zidx = r_fill[r_ti][HW-1:0];
                    end
                    n_state = S_HDONE;
                end else begin
                    n_state = S_HCMP;
                end
            end
            S_HCMP: begin
                if (cmp_eq && !r_mf) begin
                    n_mf   = 1'b1;
                    n_midx = r_hi[HW-1:0];
                end
                if (held_rdata == '0 && !r_zf) begin
                    n_zf   = 1'b1;
                    n_zidx = r_hi[HW-1:0];
                end
                n_hi    = r_hi + HCW'(1);
                n_state = S_HRD;
            end
            S_HDONE: begin
                if (r_req.func == FN_UNLOCK) begin
                    if (r_mf) begin
                        held_we    = 1'b1;
                        held_waddr = {r_ti, r_midx};
                        n_status   = ST_OK;
                    end else begin
                        n_status = ST_HELD_ERR;
                    end
                    n_state = S_OUT;
                end else if (r_mf) begin
                    n_status = ST_HELD_ERR;
                    n_state  = S_SINIT;
                end else begin
                    n_ni    = '0;
                    n_nf    = 1'b0;
                    n_ef    = 1'b0;
                    n_edge  = 1'b0;
                    n_state = S_NRD;
                end
            end
            S_NRD: begin
                n_state = S_NCMP;
            end
            S_NCMP: begin
                if (r_nvalid[r_ni] && cmp_eq) begin
                    n_nf    = 1'b1;
                    n_nidx  = r_ni;
                    n_state = S_NDONE;
                end else begin
                    if (!r_nvalid[r_ni] && !r_ef) begin
                        n_ef   = 1'b1;
                        n_eidx = r_ni;
                    end
                    if (r_ni == LAST_NODE) begin
                        n_state = S_NDONE;
                    end else begin
                        n_ni    = r_ni + LW'(1);
                        n_state = S_NRD;
                    end
                end
            end
            S_NDONE: begin
                if (r_req.func == FN_UNLOCK) begin
                    if (r_nf) begin
                        n_nvalid[r_nidx] = 1'b0;
                        n_rvalid[r_nidx] = 1'b0;
                        n_node  = r_nidx;
                        n_ci    = '0;
                        n_state = S_CRD;
                    end else begin
                        n_state = S_THR;
                    end
                end else if (!r_edge) begin
                    n_hi = '0;
                    if (r_nf) begin
                        n_node  = r_nidx;
                        n_state = S_ERD;
                    end else if (r_ef) begin
                        node_we          = 1'b1;
                        n_nvalid[r_eidx] = 1'b1;
                        n_node           = r_eidx;
                        n_state          = S_ERD;
                    end else begin
                        n_state = S_HWR;
                    end
                end else if (r_nf) begin
                    n_src   = r_nidx;
                    n_state = S_EDRD;
                end else begin
                    n_hi    = r_hi + HCW'(1);
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                if (r_hi >= r_fill[r_ti]) begin
                    n_state = S_HWR;
                end else begin
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                if (held_rdata != '0) begin
                    n_key   = held_rdata;
                    n_ni    = '0;
                    n_nf    = 1'b0;
                    n_ef    = 1'b0;
                    n_edge  = 1'b1;
                    n_state = S_NRD;
                end else begin
                    n_hi    = r_hi + HCW'(1);
                    n_state = S_ERD;
                end
            end
            S_EDRD: begin
                n_state = S_EDWR;
            end
            S_EDWR: begin
                edge_we          = 1'b1;
                edge_wdata       = (r_rvalid[r_src] ? edge_rdata : '0) | node_bit;
                n_rvalid[r_src]  = 1'b1;
                n_hi             = r_hi + HCW'(1);
                n_state          = S_ERD;
            end
            S_HWR: begin
                if (r_zf) begin
                    held_we    = 1'b1;
                    held_wdata = r_req.lock_id;
                    if (HCW'(r_zidx) == r_fill[r_ti]) begin
                        n_fill[r_ti] = r_fill[r_ti] + HCW'(1);
                    end
                end
                n_status = ST_OK;
                n_state  = S_SINIT;
            end
            S_CRD: begin
                edge_raddr = r_ci;
                n_state    = S_CWR;
            end
            S_CWR: begin
                if (r_rvalid[r_ci]) begin
                    edge_we    = 1'b1;
                    edge_waddr = r_ci;
                    edge_wdata = edge_rdata & ~node_bit;
                end
                if (r_ci == LAST_NODE) begin
                    n_state = S_THR;
                end else begin
                    n_ci    = r_ci + LW'(1);
                    n_state = S_CRD;
                end
            end
            S_SINIT: begin
                n_visit = '0;
                n_stk   = '0;
                n_root  = '0;
                n_depth = '0;
                n_state = S_SROOT;
            end
            S_SROOT: begin
                edge_raddr = r_root;
                if (r_nvalid[r_root] && !r_visit[r_root]) begin
                    n_top           = r_root;
                    n_cur           = '0;
                    n_visit[r_root] = 1'b1;
                    n_stk[r_root]   = 1'b1;
                    n_depth         = DW'(1);
                    n_state         = S_SROW;
                end else if (r_root == LAST_NODE) begin
                    n_cyc   = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_root = r_root + LW'(1);
                end
            end
            S_SROW: begin
                n_row   = r_rvalid[r_top] ? edge_rdata : '0;
                n_state = S_SSCAN;
            end
            S_SSCAN: begin
                edge_raddr = r_cur;
                if (scan_edge && r_stk[r_cur]) begin
                    n_cyc   = 1'b1;
                    n_state = S_OUT;
                end else if (scan_edge && !r_visit[r_cur]) begin
                    stk_we         = 1'b1;
                    n_visit[r_cur] = 1'b1;
                    n_stk[r_cur]   = 1'b1;
                    n_top          = r_cur;
                    n_cur          = '0;
                    n_depth        = r_depth + DW'(1);
                    n_state        = S_SROW;
                end else if (r_cur == LAST_NODE) begin
                    n_stk[r_top] = 1'b0;
                    n_depth      = dm1;
                    if (r_depth == DW'(1)) begin
                        n_state = S_SROOT;
                    end else begin
                        n_state = S_SPOP;
                    end
                end else begin
                    n_cur = r_cur + LW'(1);
                end
            end
            S_SPOP: begin
                n_top      = stk_rdata[STK_W-1:LW];
                n_cur      = stk_rdata[LW-1:0];
                edge_raddr = stk_rdata[STK_W-1:LW];
                n_state    = S_SROW;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nvalid <= '0;
            r_rvalid <= '0;
            r_visit  <= '0;
            r_stk    <= '0;
            for (int k = 0; k < THREADS; k++) begin
                r_slot[k] <= '0;
                r_fill[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_nvalid <= n_nvalid;
            r_rvalid <= n_rvalid;
            r_visit  <= n_visit;
            r_stk    <= n_stk;
            r_slot   <= n_slot;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
        end
        r_ti     <= n_ti;
        r_hi     <= n_hi;
        r_mf     <= n_mf;
        r_zf     <= n_zf;
        r_midx   <= n_midx;
        r_zidx   <= n_zidx;
        r_key    <= n_key;
        r_ni     <= n_ni;
        r_nidx   <= n_nidx;
        r_eidx   <= n_eidx;
        r_nf     <= n_nf;
        r_ef     <= n_ef;
        r_edge   <= n_edge;
        r_node   <= n_node;
        r_src    <= n_src;
        r_ci     <= n_ci;
        r_root   <= n_root;
        r_top    <= n_top;
        r_cur    <= n_cur;
        r_depth  <= n_depth;
        r_row    <= n_row;
        r_status <= n_status;
        r_cyc    <= n_cyc;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_OUT);
    assign o_rsp    = '{status: r_status, cycle_found: r_cyc};

    `LODD_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `LODD_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `LODD_ASSERT_IMP(a_top_on_stack, i_clk, i_rst_n, r_state == S_SSCAN, r_stk[r_top])
    `LODD_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_strobe, o_rsp.status <= ST_THREAD_ERR)
    `LODD_ASSERT_IMP(a_unlock_no_cycle, i_clk, i_rst_n, o_strobe && r_req.func, !o_rsp.cycle_found)

endmodule
